// File: rtl/warp_map_pixel_resampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the warp map pixel resampler
// Concurrent checks, compiled out in synthesis.
// ----------------------------------------------------------------------------
`ifndef WARP_MAP_PIXEL_RESAMPLER_ASSERT_SVH
`define WARP_MAP_PIXEL_RESAMPLER_ASSERT_SVH

`ifndef SYNTHESIS
`define WMPR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WMPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WMPR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define WMPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/wmpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpr_pkg
// Shared types and constants of the warp map pixel resampler.
// ----------------------------------------------------------------------------
package wmpr_pkg;

  localparam int DIM_BITS   = 9;
  localparam int COORD_BITS = 8;
  localparam int FRAC_BITS  = 15;
  localparam int WGT_BITS   = 16;
  localparam int PROD_BITS  = 31;
  localparam int PIX_BITS   = 16;
  localparam int SUM_SHIFT  = 30;
  localparam int REQ_BITS   = 80;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [WGT_BITS-1:0] Q15_ONE = 16'h8000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP_MODE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_VALUE   = 2'd3;

  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  typedef struct packed {
    logic [FRAC_BITS-1:0]  frac_y;
    logic [FRAC_BITS-1:0]  frac_x;
    logic signed [DIM_BITS-1:0] map_y;
    logic signed [DIM_BITS-1:0] map_x;
    logic [PIX_BITS-1:0]   store_value;
    logic [COORD_BITS-1:0] store_y;
    logic [COORD_BITS-1:0] store_x;
  } req_data_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic                interp_mode;
    logic [PIX_BITS-1:0] fill_value;
  } cfg_t;

  typedef struct packed {
    logic       store;
    logic       setup;
    logic       issue;
    logic [1:0] tap;
    logic       load;
  } dp_cmd_t;

  typedef struct packed {
    logic unmapped;
  } dp_status_t;

endpackage

// File: rtl/warp_map_pixel_resampler.sv
`timescale 1ns / 1ps
`include "warp_map_pixel_resampler_assert.svh"
// ----------------------------------------------------------------------------
// warp_map_pixel_resampler
// Source frame store with nearest or bilinear lookup of output samples.
//
// Input stream s_*: s_tuser selects store (0) or lookup (1). A store writes
// one sample and gives no result; a lookup gives one sample on m_*.
// Configuration: cfg_we/cfg_index/cfg_data write frame_width, frame_height,
// interp_mode and fill_value. The user must write them only while no request
// is in flight; the block itself does not enforce this.
// A store leaves s_tready high; a lookup holds it low until its result is
// loaded, reading neighbours over the single frame memory port (one neighbour
// read per cycle) into the two-stage multiply-accumulate behind it.
// The result appears on m_tvalid the cycle after the lookup completes.
// A held result does not block accepting the next request; a lookup only
// waits in its last cycle while the output register is still full and
// m_tready is low.
// Reset clears control state and restores the register defaults; the frame
// memory needs no clearing and is undefined until written.
// ----------------------------------------------------------------------------
module warp_map_pixel_resampler #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // store_x, store_y, store_value, map_x, map_y, frac_x, frac_y
  input  logic [wmpr_pkg::REQ_BITS-1:0]         s_tdata,
  // req_type
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // out_pixel
  output logic [wmpr_pkg::PIX_BITS-1:0]         m_tdata,
  input  logic                                  cfg_we,
  input  logic [wmpr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [wmpr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import wmpr_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  req_data_t  req;

  assign req = req_data_t'(s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= DIM_BITS'(256);
      cfg.frame_height <= DIM_BITS'(256);
      cfg.interp_mode  <= MODE_NEAREST;
      cfg.fill_value   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[DIM_BITS-1:0];
        CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[DIM_BITS-1:0];
        CFG_INTERP_MODE:  cfg.interp_mode  <= cfg_data[0];
        CFG_FILL_VALUE:   cfg.fill_value   <= cfg_data[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  wmpr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .req_type    (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .interp_mode (cfg.interp_mode),
    .status      (status),
    .cmd         (cmd)
  );

  wmpr_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .req       (req),
    .status    (status),
    .out_pixel (m_tdata)
  );

  `WMPR_ASSERT_IMP(a_load_free, clk, rst, cmd.load, !m_tvalid || m_tready, "result overwrites held output")
  `WMPR_ASSERT_NXT(a_load_valid, clk, rst, cmd.load, m_tvalid, "loaded result not presented")
  `WMPR_ASSERT_IMP(a_read_busy, clk, rst, cmd.issue, !s_tready && !cmd.store, "request accepted during reads")

endmodule

// File: rtl/wmpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpr_ctrl
// Request sequencer: accepts requests, steps the neighbour reads, drains the
// multiply-accumulate pipe and owns the output valid.
// ----------------------------------------------------------------------------
module wmpr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 req_type,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 interp_mode,
  input  wmpr_pkg::dp_status_t status,
  output wmpr_pkg::dp_cmd_t    cmd
);
  import wmpr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state, state_next;
  logic [1:0] tap, tap_next;
  logic       drain, drain_next;
  logic       out_valid;
  logic       accept;
  logic       last_tap;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign last_tap = (tap == 2'd3) || ((interp_mode == MODE_NEAREST) && (tap == 2'd0));

  always_comb begin
    state_next = state;
    tap_next   = tap;
    drain_next = drain;
    cmd        = '0;
    cmd.tap    = tap;
    unique case (state)
      ST_IDLE: begin
        cmd.store = accept && (req_type == REQ_STORE);
        cmd.setup = accept && (req_type == REQ_LOOKUP);
        if (cmd.setup) begin
          tap_next   = 2'd0;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (status.unmapped) begin
          state_next = ST_FINISH;
        end else begin
          cmd.issue = 1'b1;
          if (last_tap) begin
            drain_next = 1'b0;
            state_next = ST_DRAIN;
          end else begin
            tap_next = tap + 2'd1;
          end
        end
      end
      ST_DRAIN: begin
        drain_next = 1'b1;
        if (drain) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= 2'd0;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      drain <= drain_next;
      if (cmd.load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/wmpr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpr_datapath
// Frame memory, coordinate clamping, weight products and the blend
// accumulator with rounding and the output register.
// ----------------------------------------------------------------------------
module wmpr_datapath #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wmpr_pkg::dp_cmd_t            cmd,
  input  wmpr_pkg::cfg_t               cfg,
  input  wmpr_pkg::req_data_t          req,
  output wmpr_pkg::dp_status_t         status,
  output logic [wmpr_pkg::PIX_BITS-1:0] out_pixel
);
  import wmpr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = PROD_BITS + SAMPLE_BITS;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SUM_SHIFT - 1);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  // setup: clamp frame size and coordinates
  logic [DIM_BITS-1:0] fw, fh, wm1, hm1;
  logic [DIM_BITS-1:0] mx, my, ax, ay, axp1, ayp1, bx, by;
  logic [FRAC_BITS-1:0] fx_eff, fy_eff;

  always_comb begin
    if (cfg.frame_width == '0) fw = DIM_BITS'(1);
    else if (32'(cfg.frame_width) > MAX_WIDTH) fw = DIM_BITS'(MAX_WIDTH);
    else fw = cfg.frame_width;
    if (cfg.frame_height == '0) fh = DIM_BITS'(1);
    else if (32'(cfg.frame_height) > MAX_HEIGHT) fh = DIM_BITS'(MAX_HEIGHT);
    else fh = cfg.frame_height;
    wm1  = fw - DIM_BITS'(1);
    hm1  = fh - DIM_BITS'(1);
    mx   = {1'b0, req.map_x[COORD_BITS-1:0]};
    my   = {1'b0, req.map_y[COORD_BITS-1:0]};
    ax   = (mx > wm1) ? wm1 : mx;
    ay   = (my > hm1) ? hm1 : my;
    axp1 = ax + DIM_BITS'(1);
    ayp1 = ay + DIM_BITS'(1);
    bx   = (axp1 < wm1) ? axp1 : wm1;
    by   = (ayp1 < hm1) ? ayp1 : hm1;
    fx_eff = (cfg.interp_mode == MODE_BILINEAR) ? req.frac_x : '0;
    fy_eff = (cfg.interp_mode == MODE_BILINEAR) ? req.frac_y : '0;
  end

  logic [DIM_BITS-1:0]  ax_r, ay_r, bx_r, by_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic                 unmapped_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ax_r       <= ax;
      ay_r       <= ay;
      bx_r       <= bx;
      by_r       <= by;
      fx_r       <= fx_eff;
      fy_r       <= fy_eff;
      unmapped_r <= req.map_x[DIM_BITS-1] | req.map_y[DIM_BITS-1];
    end
  end

  assign status.unmapped = unmapped_r;

  // neighbour read and weight product
  logic [WGT_BITS-1:0] zx, zy, wa, wb;
  logic [2*WGT_BITS-1:0] wfull;
  logic [DIM_BITS-1:0] rx, ry;
  logic [AW-1:0] raddr, waddr;
  logic          wr_ok;

  always_comb begin
    zx    = Q15_ONE - {1'b0, fx_r};
    zy    = Q15_ONE - {1'b0, fy_r};
    wa    = cmd.tap[0] ? {1'b0, fx_r} : zx;
    wb    = cmd.tap[1] ? {1'b0, fy_r} : zy;
    wfull = wa * wb;
    rx    = cmd.tap[0] ? bx_r : ax_r;
    ry    = cmd.tap[1] ? by_r : ay_r;
    raddr = AW'(32'(ry) * MAX_WIDTH + 32'(rx));
    waddr = AW'(32'(req.store_y) * MAX_WIDTH + 32'(req.store_x));
    wr_ok = (32'(req.store_x) < MAX_WIDTH) && (32'(req.store_y) < MAX_HEIGHT);
  end

  logic [SAMPLE_BITS-1:0] rdata;
  logic [PROD_BITS-1:0]   wprod;
  logic [ACC_W-1:0]       term, acc, rsum;
  logic                   v1, v2;

  always_ff @(posedge clk) begin
    if (cmd.store && wr_ok) mem[waddr] <= req.store_value[SAMPLE_BITS-1:0];
    if (cmd.issue) begin
      rdata <= mem[raddr];
      wprod <= wfull[PROD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) term <= ACC_W'(rdata) * ACC_W'(wprod);
    if (cmd.setup) acc <= '0;
    else if (v2) acc <= acc + term;
  end

  assign rsum = acc + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (unmapped_r) out_pixel <= PIX_BITS'(cfg.fill_value[SAMPLE_BITS-1:0]);
      else out_pixel <= PIX_BITS'(rsum[SUM_SHIFT +: SAMPLE_BITS]);
    end
  end

endmodule
